// File: sv/skft_pkg.sv
// Shared constants, codes and types of the sorted key frequency table.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package skft_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int COUNT_WIDTH = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int INDEX_WIDTH = $clog2(TABLE_DEPTH);
  localparam int POS_WIDTH   = $clog2(TABLE_DEPTH + 1);
  localparam int CMD_WIDTH   = 2;

  typedef logic [CMD_WIDTH-1:0] command_t;

  localparam command_t CMD_INSERT = 2'd0;
  localparam command_t CMD_LOOKUP = 2'd1;
  localparam command_t CMD_READ   = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]   key;
    logic [COUNT_WIDTH-1:0] count;
  } entry_t;

endpackage

`default_nettype wire

// File: sv/skft_if.sv
// Request and result channel interfaces of the sorted key frequency table.
// Depends on skft_pkg for field widths.
`default_nettype none

interface skft_in_if;
  logic                            valid;
  logic                            ready;
  skft_pkg::command_t              command;
  logic [skft_pkg::KEY_WIDTH-1:0]  key;
  logic [skft_pkg::INDEX_WIDTH-1:0] index;

  modport source (output valid, output command, output key, output index, input ready);
  modport sink   (input valid, input command, input key, input index, output ready);
endinterface

interface skft_out_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [skft_pkg::POS_WIDTH-1:0]   position;
  logic [skft_pkg::COUNT_WIDTH-1:0] count;
  logic [skft_pkg::KEY_WIDTH-1:0]   key_out;
  logic                             table_full;
  logic [skft_pkg::POS_WIDTH-1:0]   entries_used;

  modport source (output valid, output found, output position, output count,
                  output key_out, output table_full, output entries_used, input ready);
  modport sink   (input valid, input found, input position, input count,
                  input key_out, input table_full, input entries_used, output ready);
endinterface

`default_nettype wire

// File: sv/skft_cell.sv
// One storage cell of the rotating entry chain: a key and its count.
// Depends on skft_pkg for the entry type.
`default_nettype none

module skft_cell (
  input  wire logic             clk,
  input  wire logic             shift_en,
  input  wire skft_pkg::entry_t entry_i,
  output skft_pkg::entry_t      entry_o
);

  skft_pkg::entry_t entry_r;
  skft_pkg::entry_t entry_nxt;

  // The cell takes its upstream neighbour's entry whenever the chain moves.
  always_comb begin
    entry_nxt = shift_en ? entry_i : entry_r;
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;

endmodule

`default_nettype wire

// File: sv/skft_ctrl.sv
// Head unit of the chain: handshakes, the sweep sequencer, the search and
// insert decision per passing entry, and the result register. Uses skft_pkg
// and the channel interfaces of skft_if.
`default_nettype none

module skft_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  skft_in_if.sink               in_ch,
  skft_out_if.source            out_ch,
  input  wire skft_pkg::entry_t exit_i,
  output skft_pkg::entry_t      tail_o,
  output logic                  shift_en_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  localparam logic [skft_pkg::POS_WIDTH-1:0] LAST_SLOT =
    skft_pkg::POS_WIDTH'(skft_pkg::TABLE_DEPTH - 1);
  localparam logic [skft_pkg::POS_WIDTH-1:0] FULL_USED =
    skft_pkg::POS_WIDTH'(skft_pkg::TABLE_DEPTH);

  state_t                             state_r, state_nxt;
  logic [skft_pkg::POS_WIDTH-1:0]     slot_r, slot_nxt;
  skft_pkg::command_t                 cmd_r, cmd_nxt;
  logic [skft_pkg::KEY_WIDTH-1:0]     key_r, key_nxt;
  logic [skft_pkg::INDEX_WIDTH-1:0]   idx_r, idx_nxt;
  logic                               decided_r, decided_nxt;
  logic                               shifting_r, shifting_nxt;
  skft_pkg::entry_t                   hold_r, hold_nxt;
  logic                               grow_r, grow_nxt;
  logic                               res_found_r, res_found_nxt;
  logic [skft_pkg::POS_WIDTH-1:0]     res_pos_r, res_pos_nxt;
  logic [skft_pkg::COUNT_WIDTH-1:0]   res_cnt_r, res_cnt_nxt;
  logic [skft_pkg::KEY_WIDTH-1:0]     res_kout_r, res_kout_nxt;
  logic                               res_full_r, res_full_nxt;
  logic [skft_pkg::POS_WIDTH-1:0]     used_r, used_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_found_r, out_found_nxt;
  logic [skft_pkg::POS_WIDTH-1:0]     out_pos_r, out_pos_nxt;
  logic [skft_pkg::COUNT_WIDTH-1:0]   out_cnt_r, out_cnt_nxt;
  logic [skft_pkg::KEY_WIDTH-1:0]     out_kout_r, out_kout_nxt;
  logic                               out_full_r, out_full_nxt;
  logic [skft_pkg::POS_WIDTH-1:0]     out_used_r, out_used_nxt;

  logic                               is_search;
  logic                               at_used;
  logic                               key_ge;
  logic                               key_eq;
  logic [skft_pkg::COUNT_WIDTH-1:0]   cnt_inc;

  assign is_search = (cmd_r == skft_pkg::CMD_INSERT) || (cmd_r == skft_pkg::CMD_LOOKUP);
  assign at_used   = (slot_r == used_r);
  assign key_ge    = (exit_i.key >= key_r);
  assign key_eq    = (exit_i.key == key_r);
  assign cnt_inc   = (exit_i.count == skft_pkg::COUNT_MAX) ?
                     exit_i.count : exit_i.count + skft_pkg::COUNT_WIDTH'(1);

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    decided_nxt   = decided_r;
    shifting_nxt  = shifting_r;
    hold_nxt      = hold_r;
    grow_nxt      = grow_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    res_cnt_nxt   = res_cnt_r;
    res_kout_nxt  = res_kout_r;
    res_full_nxt  = res_full_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_cnt_nxt   = out_cnt_r;
    out_kout_nxt  = out_kout_r;
    out_full_nxt  = out_full_r;
    out_used_nxt  = out_used_r;
    tail_o        = exit_i;
    shift_en_o    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt       = in_ch.command;
          key_nxt       = in_ch.key;
          idx_nxt       = in_ch.index;
          slot_nxt      = '0;
          decided_nxt   = 1'b0;
          shifting_nxt  = 1'b0;
          grow_nxt      = 1'b0;
          res_found_nxt = 1'b0;
          res_pos_nxt   = (in_ch.command == skft_pkg::CMD_READ) ?
                          skft_pkg::POS_WIDTH'(in_ch.index) : '0;
          res_cnt_nxt   = '0;
          res_kout_nxt  = '0;
          res_full_nxt  = 1'b0;
          state_nxt     = ST_SWEEP;
        end
      end

      ST_SWEEP: begin
        shift_en_o = 1'b1;
        slot_nxt   = slot_r + skft_pkg::POS_WIDTH'(1);
        if (shifting_r) begin
          // Entries above the insertion point move up by one slot.
          tail_o   = hold_r;
          hold_nxt = exit_i;
        end else if (is_search && !decided_r && (at_used || key_ge)) begin
          decided_nxt = 1'b1;
          res_pos_nxt = slot_r;
          if (!at_used && key_eq) begin
            res_found_nxt = 1'b1;
            if (cmd_r == skft_pkg::CMD_INSERT) begin
              tail_o.count = cnt_inc;
              res_cnt_nxt  = cnt_inc;
            end else begin
              res_cnt_nxt = exit_i.count;
            end
          end else if (cmd_r == skft_pkg::CMD_INSERT) begin
            if (used_r == FULL_USED) begin
              res_full_nxt = 1'b1;
            end else begin
              tail_o.key   = key_r;
              tail_o.count = skft_pkg::COUNT_WIDTH'(1);
              hold_nxt     = exit_i;
              shifting_nxt = 1'b1;
              grow_nxt     = 1'b1;
              res_cnt_nxt  = skft_pkg::COUNT_WIDTH'(1);
            end
          end
        end
        if ((cmd_r == skft_pkg::CMD_READ) && (slot_r == skft_pkg::POS_WIDTH'(idx_r)) &&
            (skft_pkg::POS_WIDTH'(idx_r) < used_r)) begin
          res_found_nxt = 1'b1;
          res_cnt_nxt   = exit_i.count;
          res_kout_nxt  = exit_i.key;
        end
        if (slot_r == LAST_SLOT) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          // A search that never met a key at or above its own ends past the
          // last entry; for an insert that only happens on a full table.
          used_nxt      = used_r + skft_pkg::POS_WIDTH'(grow_r);
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = (is_search && !decided_r) ? used_r : res_pos_r;
          out_cnt_nxt   = res_cnt_r;
          out_kout_nxt  = res_kout_r;
          out_full_nxt  = res_full_r ||
                          ((cmd_r == skft_pkg::CMD_INSERT) && !decided_r);
          out_used_nxt  = used_r + skft_pkg::POS_WIDTH'(grow_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    slot_r      <= slot_nxt;
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    idx_r       <= idx_nxt;
    decided_r   <= decided_nxt;
    shifting_r  <= shifting_nxt;
    hold_r      <= hold_nxt;
    grow_r      <= grow_nxt;
    res_found_r <= res_found_nxt;
    res_pos_r   <= res_pos_nxt;
    res_cnt_r   <= res_cnt_nxt;
    res_kout_r  <= res_kout_nxt;
    res_full_r  <= res_full_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_kout_r  <= out_kout_nxt;
    out_full_r  <= out_full_nxt;
    out_used_r  <= out_used_nxt;
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.position     = out_pos_r;
  assign out_ch.count        = out_cnt_r;
  assign out_ch.key_out      = out_kout_r;
  assign out_ch.table_full   = out_full_r;
  assign out_ch.entries_used = out_used_r;

endmodule

`default_nettype wire

// File: sv/sorted_key_frequency_table.sv
// Sorted key frequency table, a ring of TABLE_DEPTH (1024) cells. After a request is
// accepted, the ring makes one full rotation past the head unit (the sweep) and then the
// result register is loaded. The next request is taken only once the block is idle again;
// an uncollected result stalls the loading of the result register and so the next request.
// Reset (rst_n, synchronous, active low) empties the table and clears the handshakes.
// Depends on skft_pkg, skft_if, skft_cell and skft_ctrl.
`default_nettype none

module sorted_key_frequency_table (
  input  wire logic  clk,
  input  wire logic  rst_n,
  skft_in_if.sink    in_ch,
  skft_out_if.source out_ch
);

  // The table is a ring of cells. Cell 0 faces the head unit and cell
  // TABLE_DEPTH-1 takes what the head unit hands back. Between requests, cell j
  // holds entry j of the ascending key order, and only the first entries_used
  // cells are meaningful. The cell contents are not cleared by reset, as entries
  // at or above the fill count are never used.
  //
  // A request rotates the ring once, so the entries pass the head unit in slot order
  // and, after TABLE_DEPTH shifts, every entry is back in its own cell.
  // On the way the head unit:
  //   - stops at the first entry whose key is at or above the request key, or
  //     at the fill count, which gives the match or the insertion point;
  //   - on an insert hit, hands the entry back with its count raised (it
  //     saturates at all ones);
  //   - on an insert miss with room left, hands back the new key with a count of one and
  //     from then on delays the stream by one entry, which moves all higher
  //     entries up by one slot;
  //   - on a read, captures the entry at the requested index.
  // The result is then placed in an output register, so a new request can be
  // taken while the previous result still waits to be collected.

  skft_pkg::entry_t cell_q [skft_pkg::TABLE_DEPTH];
  skft_pkg::entry_t tail;
  logic             shift_en;

  for (genvar i = 0; i < skft_pkg::TABLE_DEPTH; i++) begin : g_cell
    if (i == skft_pkg::TABLE_DEPTH - 1) begin : g_tail
      skft_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .entry_i  (tail),
        .entry_o  (cell_q[i])
      );
    end else begin : g_body
      skft_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .entry_i  (cell_q[i+1]),
        .entry_o  (cell_q[i])
      );
    end
  end

  skft_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .exit_i     (cell_q[0]),
    .tail_o     (tail),
    .shift_en_o (shift_en)
  );

endmodule

`default_nettype wire

// File: sv/skft_checker.sv
// Port-level checks of the sorted key frequency table, bound to the top level.
// Depends on skft_pkg for widths and the table depth.
`default_nettype none

module skft_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic                             out_found,
  input wire logic [skft_pkg::COUNT_WIDTH-1:0] out_count,
  input wire logic                             out_table_full,
  input wire logic [skft_pkg::POS_WIDTH-1:0]   out_entries_used
);

  // A result is held until it is collected.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was collected");

  // One request at a time: no request is taken in the cycle after one was.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  // The fill count never passes the table depth.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entries_used <= skft_pkg::POS_WIDTH'(skft_pkg::TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // A dropped insert only happens on a full table and reports nothing found.
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |->
      !out_found && (out_count == '0) &&
      (out_entries_used == skft_pkg::POS_WIDTH'(skft_pkg::TABLE_DEPTH)))
    else $error("table full reported on a table that is not full");

  // Any stored entry has been counted at least once.
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_count != '0)
    else $error("entry found with a zero count");

endmodule

bind sorted_key_frequency_table skft_checker u_skft_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_found        (out_ch.found),
  .out_count        (out_ch.count),
  .out_table_full   (out_ch.table_full),
  .out_entries_used (out_ch.entries_used)
);

`default_nettype wire

// File: sim/tb_sorted_key_frequency_table.sv
// Self-checking testbench of the sorted key frequency table: directed and random
// requests, a scoreboard class that predicts every result, idling and back-pressure.
// Depends on skft_pkg, skft_if and the sorted_key_frequency_table RTL.
`timescale 1ns / 100ps

module tb_sorted_key_frequency_table;

  // Command 3 has no meaning; the block must answer it without touching the table.
  localparam skft_pkg::command_t CMD_UNUSED     = 2'd3;
  // The limits sit well above the time that one request takes inside the block.
  localparam int                 IDLE_LIMIT     = 20000;
  localparam int                 HOLD_CYCLES    = 6000;
  localparam int                 DRAIN_CYCLES   = 1100;
  localparam int                 PHASE_REQUESTS = 137;

  // Everything the block reports for one request.
  typedef struct packed {
    logic                             found;
    logic [skft_pkg::POS_WIDTH-1:0]   position;
    logic [skft_pkg::COUNT_WIDTH-1:0] count;
    logic [skft_pkg::KEY_WIDTH-1:0]   key_out;
    logic                             table_full;
    logic [skft_pkg::POS_WIDTH-1:0]   entries_used;
  } table_result_t;

  // Scoreboard: keeps its own sorted copy of the table, works out the result of
  // every accepted request and checks the results in the order they come back.
  class sorted_table_tracker;
    logic [skft_pkg::KEY_WIDTH-1:0]   stored_keys   [skft_pkg::TABLE_DEPTH];
    logic [skft_pkg::COUNT_WIDTH-1:0] stored_counts [skft_pkg::TABLE_DEPTH];
    int                               used;
    table_result_t                    pending_results[$];
    int                               mismatches;

    function new();
      used       = 0;
      mismatches = 0;
    endfunction

    function void note_request(skft_pkg::command_t cmd, logic [skft_pkg::KEY_WIDTH-1:0] k,
                               logic [skft_pkg::INDEX_WIDTH-1:0] idx);
      table_result_t r;
      int            lo;
      int            hi;
      int            mid;
      int            i;
      bit            hit;
      r   = '0;
      hit = 1'b0;
      if (cmd == skft_pkg::CMD_INSERT || cmd == skft_pkg::CMD_LOOKUP) begin
        // Binary search over the occupied part; lo ends on the insertion point.
        lo = 0;
        hi = used - 1;
        while (lo <= hi && !hit) begin
          mid = (lo + hi) / 2;
          if (stored_keys[mid] < k) begin
            lo = mid + 1;
          end else if (stored_keys[mid] > k) begin
            hi = mid - 1;
          end else begin
            hit = 1'b1;
            lo  = mid;
          end
        end
        r.position = skft_pkg::POS_WIDTH'(lo);
        if (hit) begin
          r.found = 1'b1;
          if (cmd == skft_pkg::CMD_INSERT && stored_counts[lo] != skft_pkg::COUNT_MAX) begin
            stored_counts[lo] = stored_counts[lo] + skft_pkg::COUNT_WIDTH'(1);
          end
          r.count = stored_counts[lo];
        end else if (cmd == skft_pkg::CMD_INSERT) begin
          if (used == skft_pkg::TABLE_DEPTH) begin
            r.table_full = 1'b1;
          end else begin
            for (i = used; i > lo; i--) begin
              stored_keys[i]   = stored_keys[i-1];
              stored_counts[i] = stored_counts[i-1];
            end
            stored_keys[lo]   = k;
            stored_counts[lo] = skft_pkg::COUNT_WIDTH'(1);
            used++;
            r.count = skft_pkg::COUNT_WIDTH'(1);
          end
        end
      end else if (cmd == skft_pkg::CMD_READ) begin
        r.position = skft_pkg::POS_WIDTH'(idx);
        if (idx < used) begin
          r.found   = 1'b1;
          r.count   = stored_counts[idx];
          r.key_out = stored_keys[idx];
        end
      end
      r.entries_used = skft_pkg::POS_WIDTH'(used);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [skft_pkg::KEY_WIDTH-1:0] want,
                                logic [skft_pkg::KEY_WIDTH-1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        compare_field("found", skft_pkg::KEY_WIDTH'(want.found),
                      skft_pkg::KEY_WIDTH'(got.found));
        compare_field("position", skft_pkg::KEY_WIDTH'(want.position),
                      skft_pkg::KEY_WIDTH'(got.position));
        compare_field("count", skft_pkg::KEY_WIDTH'(want.count),
                      skft_pkg::KEY_WIDTH'(got.count));
        compare_field("key_out", want.key_out, got.key_out);
        compare_field("table_full", skft_pkg::KEY_WIDTH'(want.table_full),
                      skft_pkg::KEY_WIDTH'(got.table_full));
        compare_field("entries_used", skft_pkg::KEY_WIDTH'(want.entries_used),
                      skft_pkg::KEY_WIDTH'(got.entries_used));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  skft_in_if  in_ch();
  skft_out_if out_ch();

  sorted_table_tracker tracker = new();

  // Stimulus bookkeeping: every key ever sent as an insert, with or without room,
  // both as a set (for picking fresh keys) and as a list (for picking hits).
  bit                             key_seen[logic [skft_pkg::KEY_WIDTH-1:0]];
  logic [skft_pkg::KEY_WIDTH-1:0] known_keys[$];

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_request;
  bit hold_done;
  int quiet_cycles;
  int leftover;

  sorted_key_frequency_table dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The monitors sample at the rising edge, where every input has been steady since
  // the falling edge, so an accepted request is noted before its result can return.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      tracker.note_request(in_ch.command, in_ch.key, in_ch.index);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.check_result(table_result_t'{found:        out_ch.found,
                                           position:     out_ch.position,
                                           count:        out_ch.count,
                                           key_out:      out_ch.key_out,
                                           table_full:   out_ch.table_full,
                                           entries_used: out_ch.entries_used});
    end
  end

  // Watchdog: a long run of cycles with no handshake on either side means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver. Normally it stalls at random; on a hold request it keeps ready
  // low once for a long stretch, counted here, so that the block backs up into its input.
  initial begin
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offers one request and returns at the rising edge at which it is accepted.
  // Valid is only lowered for an idle gap, so a back-to-back request keeps it high.
  task automatic send_request(input skft_pkg::command_t cmd,
                              input logic [skft_pkg::KEY_WIDTH-1:0] k,
                              input logic [skft_pkg::INDEX_WIDTH-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.key     <= k;
    in_ch.index   <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [skft_pkg::INDEX_WIDTH-1:0] random_index();
    return skft_pkg::INDEX_WIDTH'($urandom_range(0, skft_pkg::TABLE_DEPTH - 1));
  endfunction

  // Insert with a random index as noise; the block must ignore the index here.
  task automatic insert_key(input logic [skft_pkg::KEY_WIDTH-1:0] k);
    if (!key_seen.exists(k)) begin
      key_seen[k] = 1'b1;
      known_keys.push_back(k);
    end
    send_request(skft_pkg::CMD_INSERT, k, random_index());
  endtask

  // Stops offering and waits until every outstanding request has its result.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [skft_pkg::KEY_WIDTH-1:0] pick_known_key();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // A key not yet inserted: plain random, a neighbour of a stored key (to probe the
  // search boundaries), one with zero bytes, or one near either end of the range.
  function automatic logic [skft_pkg::KEY_WIDTH-1:0] fresh_key();
    logic [skft_pkg::KEY_WIDTH-1:0] k;
    int                             b;
    do begin
      k = $urandom;
      case ($urandom_range(0, 4))
        1: begin
          if (known_keys.size() != 0) begin
            k = pick_known_key() + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
          end
        end
        2: begin
          for (b = 0; b < 4; b++) begin
            if ($urandom_range(0, 1)) k[b*8 +: 8] = 8'h00;
          end
        end
        3: begin
          k = $urandom_range(0, 255);
          if ($urandom_range(0, 1)) k = ~k;
        end
        default: ;
      endcase
    end while (key_seen.exists(k));
    return k;
  endfunction

  // One random request. Most are inserts and lookups on a mix of stored and fresh
  // keys, so the table grows and the counts climb; reads look inside and past the end.
  task automatic random_request();
    int                               roll;
    int                               top;
    logic [skft_pkg::INDEX_WIDTH-1:0] idx;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      if (known_keys.size() != 0 && $urandom_range(0, 1)) begin
        insert_key(pick_known_key());
      end else begin
        insert_key(fresh_key());
      end
    end else if (roll < 72) begin
      send_request(skft_pkg::CMD_LOOKUP,
                   (known_keys.size() != 0 && $urandom_range(0, 1)) ?
                     pick_known_key() : fresh_key(),
                   random_index());
    end else if (roll < 95) begin
      top = known_keys.size() + 2;
      if (top > skft_pkg::TABLE_DEPTH - 1) top = skft_pkg::TABLE_DEPTH - 1;
      idx = $urandom_range(0, 1) ? skft_pkg::INDEX_WIDTH'($urandom_range(0, top)) :
                                   random_index();
      send_request(skft_pkg::CMD_READ, $urandom, idx);
    end else begin
      send_request(CMD_UNUSED, $urandom, random_index());
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.command  = skft_pkg::CMD_INSERT;
    in_ch.key      = '0;
    in_ch.index    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. On the empty table: a lookup miss, reads past the end at both
    // index extremes, and the unused command.
    send_request(skft_pkg::CMD_LOOKUP, 32'h0000_0000, '0);
    send_request(skft_pkg::CMD_READ, 32'hFFFF_FFFF, '0);
    send_request(skft_pkg::CMD_READ, 32'h0000_0000, '1);
    send_request(CMD_UNUSED, 32'hA5A5_5A5A, 10'h2AA);
    // Key extremes, a repeat that raises a count, and keys whose order depends on
    // the first byte being most significant or that carry zero bytes.
    insert_key(32'h8000_0000);
    insert_key(32'h0000_0000);
    insert_key(32'hFFFF_FFFF);
    insert_key(32'h0000_0000);
    insert_key(32'h7FFF_FFFF);
    insert_key(32'h0100_0000);
    insert_key(32'h00FF_FFFF);
    insert_key(32'h4100_0000);
    insert_key(32'h4100_0041);
    insert_key(32'h0000_0001);
    // Lookups: a hit at the top, a miss between two entries, a hit with count two.
    send_request(skft_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, '0);
    send_request(skft_pkg::CMD_LOOKUP, 32'h8000_0001, '0);
    send_request(skft_pkg::CMD_LOOKUP, 32'h0000_0000, '1);
    // Reads of the first and last entries and of the first index past the end.
    send_request(skft_pkg::CMD_READ, '0, 10'd0);
    send_request(skft_pkg::CMD_READ, '0, 10'd8);
    send_request(skft_pkg::CMD_READ, '0, 10'd9);
    insert_key(32'hFFFF_FFFF);
    send_request(CMD_UNUSED, '1, '1);
    wait_drained();

    // Back-pressure: the receiver holds off while requests keep coming, until the
    // block stops accepting; then everything drains before the next phase.
    @(posedge clk);
    hold_request = 1'b1;
    repeat (8) random_request();
    wait (hold_done);
    wait_drained();

    // Random requests under four idling patterns, draining between them.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      repeat (PHASE_REQUESTS) random_request();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    leftover = tracker.pending_results.size();
    if (leftover != 0) begin
      $display("%0t: %0d results never arrived", $time, leftover);
    end
    if (tracker.mismatches == 0 && leftover == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
